// ===== design/becl_pkg.sv =====
// ----------------------------------------------------------------------------
// becl_pkg
// Shared widths, constants and types of the back-emf current limiter.
// ----------------------------------------------------------------------------
package becl_pkg;

	localparam int DATA_W     = 8;           // signed command, velocity and pwm
	localparam int MAG_W      = 7;           // magnitudes 0..127
	localparam int LIM_W      = 7;           // limit registers
	localparam int DIV_W      = 8;           // divisor 127 +/- emf, 1..253
	localparam int QUO_W      = 7;           // quotient bits, one cell per bit
	localparam int NUM_W      = 2 * QUO_W;   // numerator limit*127
	localparam int PROD_W     = MAG_W + DIV_W;
	localparam int FULL_SCALE = 127;
	localparam int EMF_CLAMP  = 126;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(40);

	// emf gain and shift per motor and gear
	localparam int LG_HI_MUL = 17;
	localparam int LG_HI_SH  = 2;
	localparam int LG_LO_MUL = 243;
	localparam int LG_LO_SH  = 4;
	localparam int SM_HI_MUL = 81;
	localparam int SM_HI_SH  = 4;
	localparam int SM_LO_MUL = 289;
	localparam int SM_LO_SH  = 4;

	typedef enum logic [0:0] {
		REG_LARGE_LIMIT,
		REG_SMALL_LIMIT
	} cfg_reg_t;

	// restoring divider word handed from cell to cell
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [QUO_W-1:0] num;
		logic [QUO_W-1:0] quo;
		logic [DIV_W-1:0] divisor;
	} div_t;

	// request fields that ride alongside the divider chain
	typedef struct packed {
		logic [DATA_W-1:0] cmd;
		logic              neg;
		logic              lim_large;
		logic              lim_small;
	} side_t;

	typedef struct packed {
		logic [DATA_W-1:0] large_pwm;
		logic [DATA_W-1:0] small_pwm;
		logic              limited;
	} result_t;

endpackage

// ===== design/becl_front.sv =====
// ----------------------------------------------------------------------------
// becl_front
// Saturation, back-emf estimate and limit check; seeds the divider chain.
// ----------------------------------------------------------------------------
module becl_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [becl_pkg::DATA_W-1:0] drive_command,
	input  logic [becl_pkg::DATA_W-1:0] wheel_velocity,
	input  logic                        in_high_gear,
	input  logic                        in_low_gear,
	input  logic [becl_pkg::LIM_W-1:0]  large_limit,
	input  logic [becl_pkg::LIM_W-1:0]  small_limit,
	output logic                        out_valid,
	output becl_pkg::side_t             side,
	output becl_pkg::div_t              div_large,
	output becl_pkg::div_t              div_small
);

	localparam int DW = becl_pkg::DATA_W;
	localparam int MW = becl_pkg::MAG_W;
	localparam int VW = becl_pkg::DIV_W;
	localparam int NW = becl_pkg::NUM_W;
	localparam int PW = becl_pkg::PROD_W;
	localparam int QW = becl_pkg::QUO_W;

	function automatic logic [DW-1:0] sat(input logic [DW-1:0] x);
		logic [DW-1:0] min_neg;
		min_neg = {1'b1, {(DW-1){1'b0}}};
		return (x == min_neg) ? (min_neg + DW'(1)) : x;
	endfunction

	function automatic logic [MW-1:0] magnitude(input logic [DW-1:0] x);
		logic [DW-1:0] a;
		a = x[DW-1] ? (~x + DW'(1)) : x;
		return a[MW-1:0];
	endfunction

	function automatic logic [MW-1:0] emf_mag(input logic [MW-1:0] v, input int mul,
		input int sh);
		logic [15:0] prod;
		logic [15:0] r;
		prod = 16'(v) * 16'(mul);
		r    = prod >> sh;
		if (r > 16'(becl_pkg::EMF_CLAMP)) begin
			return MW'(becl_pkg::EMF_CLAMP);
		end
		return r[MW-1:0];
	endfunction

	// opp: effective emf negative after folding in the command sign
	function automatic logic [VW-1:0] divisor(input logic [MW-1:0] r, input logic opp);
		return opp ? (VW'(becl_pkg::FULL_SCALE) + VW'(r))
		           : (VW'(becl_pkg::FULL_SCALE) - VW'(r));
	endfunction

	logic [DW-1:0] cmd_sat, vel_sat;
	logic [MW-1:0] cmd_mag, vel_mag, emf_large, emf_small;
	logic          opp;

	always_comb begin
		cmd_sat = sat(drive_command);
		vel_sat = sat(wheel_velocity);
		cmd_mag = magnitude(cmd_sat);
		vel_mag = magnitude(vel_sat);
		opp     = vel_sat[DW-1] ^ cmd_sat[DW-1];
		priority if (in_high_gear) begin
			emf_large = emf_mag(vel_mag, becl_pkg::LG_HI_MUL, becl_pkg::LG_HI_SH);
			emf_small = emf_mag(vel_mag, becl_pkg::SM_HI_MUL, becl_pkg::SM_HI_SH);
		end else if (in_low_gear) begin
			emf_large = emf_mag(vel_mag, becl_pkg::LG_LO_MUL, becl_pkg::LG_LO_SH);
			emf_small = emf_mag(vel_mag, becl_pkg::SM_LO_MUL, becl_pkg::SM_LO_SH);
		end else begin
			emf_large = '0;
			emf_small = '0;
		end
	end

	logic          vld_s1;
	logic [DW-1:0] cmd_s1;
	logic [MW-1:0] mag_s1;
	logic [VW-1:0] dl_s1, ds_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_sat;
			mag_s1 <= cmd_mag;
			dl_s1  <= divisor(emf_large, opp);
			ds_s1  <= divisor(emf_small, opp);
		end
	end

	// vr > limit  <=>  mag*d >= (limit+1)*127, so no divide for the check
	logic [PW-1:0] prod_l, prod_s;
	logic [NW-1:0] nl, ns;
	logic          lim_l, lim_s;

	always_comb begin
		prod_l = PW'(mag_s1) * PW'(dl_s1);
		prod_s = PW'(mag_s1) * PW'(ds_s1);
		nl     = NW'(large_limit) * NW'(becl_pkg::FULL_SCALE);
		ns     = NW'(small_limit) * NW'(becl_pkg::FULL_SCALE);
		lim_l  = prod_l >= (PW'(nl) + PW'(becl_pkg::FULL_SCALE));
		lim_s  = prod_s >= (PW'(ns) + PW'(becl_pkg::FULL_SCALE));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side.cmd          <= cmd_s1;
			side.neg          <= cmd_s1[DW-1];
			side.lim_large    <= lim_l;
			side.lim_small    <= lim_s;
			div_large.rem     <= VW'(nl[NW-1:QW]);
			div_large.num     <= nl[QW-1:0];
			div_large.quo     <= '0;
			div_large.divisor <= dl_s1;
			div_small.rem     <= VW'(ns[NW-1:QW]);
			div_small.num     <= ns[QW-1:0];
			div_small.quo     <= '0;
			div_small.divisor <= ds_s1;
		end
	end

endmodule

// ===== design/becl_div_cell.sv =====
// ----------------------------------------------------------------------------
// becl_div_cell
// One restoring division step: brings in a numerator bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module becl_div_cell (
	input  logic           clk,
	input  logic           en,
	input  becl_pkg::div_t d_in,
	output becl_pkg::div_t d_out
);

	localparam int VW = becl_pkg::DIV_W;
	localparam int QW = becl_pkg::QUO_W;

	logic [VW:0] trial, diff;
	logic        ge;

	always_comb begin
		trial = {d_in.rem, d_in.num[QW-1]};
		diff  = trial - {1'b0, d_in.divisor};
		ge    = trial >= {1'b0, d_in.divisor};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out.rem     <= ge ? diff[VW-1:0] : trial[VW-1:0];
			d_out.num     <= {d_in.num[QW-2:0], 1'b0};
			d_out.quo     <= {d_in.quo[QW-2:0], ge};
			d_out.divisor <= d_in.divisor;
		end
	end

endmodule

// ===== design/back_emf_current_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// back_emf_current_limiter_unit
// Back-emf current limiter for a large and a small drive motor.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tdata: command, velocity; tuser: gears
//  m_*      out        m_tvalid/m_tready  tdata: large, small pwm; tuser: limited
//  cfg_*    in         cfg_we             cfg_index, cfg_data
//
//  one request per cycle unless the skid stage is full; the path is two front
//  stages, a chain of seven divider cells (one quotient bit each), then the
//  output register. a two-entry output register and skid stage decouple the
//  sides; input stalls only when both are full. reset sets both limits to 40
//  and empties the pipeline.
// ----------------------------------------------------------------------------
module back_emf_current_limiter_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [15:0]                s_tdata,   // drive_command, wheel_velocity
	input  logic [1:0]                 s_tuser,   // in_high_gear, in_low_gear
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata,   // large_motor_pwm, small_motor_pwm
	output logic [0:0]                 m_tuser,   // drive_limited
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [becl_pkg::LIM_W-1:0] cfg_data
);

	localparam int DW = becl_pkg::DATA_W;
	localparam int QW = becl_pkg::QUO_W;

	logic [becl_pkg::LIM_W-1:0] large_limit_q, small_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			large_limit_q <= becl_pkg::LIMIT_RESET;
			small_limit_q <= becl_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (becl_pkg::cfg_reg_t'(cfg_index))
				becl_pkg::REG_LARGE_LIMIT: large_limit_q <= cfg_data;
				becl_pkg::REG_SMALL_LIMIT: small_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	logic skid_valid_q, out_valid_q;

	assign adv      = !skid_valid_q;
	assign s_tready = adv;

	logic            front_valid;
	becl_pkg::side_t front_side;
	becl_pkg::div_t  div_l [QW+1];
	becl_pkg::div_t  div_s [QW+1];
	logic            vld_s [QW];
	becl_pkg::side_t side_s [QW];

	becl_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (adv),
		.in_valid       (s_tvalid),
		.drive_command  (s_tdata[7:0]),
		.wheel_velocity (s_tdata[15:8]),
		.in_high_gear   (s_tuser[0]),
		.in_low_gear    (s_tuser[1]),
		.large_limit    (large_limit_q),
		.small_limit    (small_limit_q),
		.out_valid      (front_valid),
		.side           (front_side),
		.div_large      (div_l[0]),
		.div_small      (div_s[0])
	);

	for (genvar i = 0; i < QW; i++) begin : g_chain
		logic            vld_in;
		becl_pkg::side_t side_in;

		if (i == 0) begin : g_head
			assign vld_in  = front_valid;
			assign side_in = front_side;
		end else begin : g_link
			assign vld_in  = vld_s[i-1];
			assign side_in = side_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[i] <= side_in;
			end
		end

		becl_div_cell u_cell_l (.clk(clk), .en(adv), .d_in(div_l[i]), .d_out(div_l[i+1]));
		becl_div_cell u_cell_s (.clk(clk), .en(adv), .d_in(div_s[i]), .d_out(div_s[i+1]));
	end

	function automatic logic [DW-1:0] pick(input logic [DW-1:0] cmd, input logic neg,
		input logic lim, input logic [QW-1:0] quo);
		logic [DW-1:0] q;
		q = DW'(quo);
		if (!lim) begin
			return cmd;
		end
		return neg ? (~q + DW'(1)) : q;
	endfunction

	becl_pkg::side_t last;
	becl_pkg::result_t res, out_q, skid_q;
	logic last_vld;

	always_comb begin
		last          = side_s[QW-1];
		last_vld      = vld_s[QW-1];
		res.large_pwm = pick(last.cmd, last.neg, last.lim_large, div_l[QW].quo);
		res.small_pwm = pick(last.cmd, last.neg, last.lim_small, div_s[QW].quo);
		res.limited   = last.lim_large | last.lim_small;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (last_vld) begin
			if (out_valid_q && !m_tready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (last_vld) begin
			if (out_valid_q && !m_tready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.small_pwm, out_q.large_pwm};
	assign m_tuser  = out_q.limited;

	// skid holds a request only behind a stalled output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid full while output empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready && last_vld))
		else $error("skid filled without a stalled output");

	// negation of the quotient must never reach minus 128
	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80))
		else $error("pwm out of range");

	a_unlimited_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == m_tdata[15:8])
		else $error("unlimited outputs differ");

endmodule

// ===== sim/tb_back_emf_current_limiter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_back_emf_current_limiter_unit
// Streams drive requests through the back-emf current limiter and checks
// every result against a local model of the emf estimate and limiting math
// or typed expected values. A directed table covers extremes, gears and
// zero limits; random phases follow at several limit settings, with random
// idling on both sides and one long receiver hold-off filling the pipeline.
// ----------------------------------------------------------------------------
module tb_back_emf_current_limiter_unit;

	localparam int HALF_PERIOD  = 6;
	localparam int DRAIN_CYCLES = 14;
	localparam int LONG_HOLD    = 90;
	localparam int PHASE_ITEMS  = 75;
	localparam int NUM_PHASES   = 8;

	// emf gain and shift per motor and gear
	localparam int LARGE_HI_GAIN = 17;
	localparam int LARGE_HI_SHR  = 2;
	localparam int LARGE_LO_GAIN = 243;
	localparam int LARGE_LO_SHR  = 4;
	localparam int SMALL_HI_GAIN = 81;
	localparam int SMALL_HI_SHR  = 4;
	localparam int SMALL_LO_GAIN = 289;
	localparam int SMALL_LO_SHR  = 4;
	localparam int PWM_FULL      = 127;
	localparam int EMF_MAX       = 126;

	typedef struct {
		logic [7:0]         cmd;
		logic [7:0]         vel;
		logic               hi;
		logic               lo;
		bit                 typed;
		becl_pkg::result_t  res;
	} drive_row_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [15:0]                s_tdata   = '0;   // drive_command, wheel_velocity
	logic [1:0]                 s_tuser   = '0;   // in_high_gear, in_low_gear
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [15:0]                m_tdata;          // large_motor_pwm, small_motor_pwm
	logic [0:0]                 m_tuser;          // drive_limited
	logic                       cfg_we    = 1'b0;
	logic [0:0]                 cfg_index = '0;
	logic [becl_pkg::LIM_W-1:0] cfg_data  = '0;

	becl_pkg::result_t pending_pwm[$];
	drive_row_t        drive_rows[$];
	int                large_lim = 40;
	int                small_lim = 40;
	int                mismatch_cnt = 0;
	bit                no_idle = 1'b0;
	bit                hold_req = 1'b0;

	back_emf_current_limiter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	// -------- prediction --------

	function automatic int sat_byte(logic [7:0] raw);
		int x;
		x = int'($signed(raw));
		if (x < -PWM_FULL) x = -PWM_FULL;
		return x;
	endfunction

	function automatic int emf_est(int vel, logic hi, logic lo, int hi_gain, int hi_shr,
			int lo_gain, int lo_shr);
		int mag;
		int e;
		mag = (vel < 0) ? -vel : vel;
		if (hi) e = (mag * hi_gain) >>> hi_shr;
		else if (lo) e = (mag * lo_gain) >>> lo_shr;
		else e = 0;
		if (e > EMF_MAX) e = EMF_MAX;
		return (vel < 0) ? -e : e;
	endfunction

	function automatic int motor_pwm(int cmd, int emf, int lim, inout bit limited);
		int mag;
		int e;
		int vr;
		int lim_out;
		if (cmd == 0) return 0;
		mag = (cmd < 0) ? -cmd : cmd;
		e = (cmd < 0) ? -emf : emf;
		if (e > EMF_MAX) e = EMF_MAX;
		else if (e < -EMF_MAX) e = -EMF_MAX;
		vr = mag * (PWM_FULL - e) / PWM_FULL;
		if (vr > lim) begin
			limited = 1'b1;
			lim_out = lim * PWM_FULL / (PWM_FULL - e);
			return (cmd < 0) ? -lim_out : lim_out;
		end
		return cmd;
	endfunction

	function automatic becl_pkg::result_t predict_pwm(logic [7:0] cmd_raw, logic [7:0] vel_raw,
			logic hi, logic lo);
		int cmd;
		int vel;
		int p_large;
		int p_small;
		bit limited;
		becl_pkg::result_t r;
		cmd = sat_byte(cmd_raw);
		vel = sat_byte(vel_raw);
		limited = 1'b0;
		p_large = motor_pwm(cmd, emf_est(vel, hi, lo, LARGE_HI_GAIN, LARGE_HI_SHR,
			LARGE_LO_GAIN, LARGE_LO_SHR), large_lim, limited);
		p_small = motor_pwm(cmd, emf_est(vel, hi, lo, SMALL_HI_GAIN, SMALL_HI_SHR,
			SMALL_LO_GAIN, SMALL_LO_SHR), small_lim, limited);
		r.large_pwm = 8'(p_large);
		r.small_pwm = 8'(p_small);
		r.limited   = limited;
		return r;
	endfunction

	// -------- stimulus helpers --------

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic logic [7:0] pick_byte(bit velocity);
		int r;
		int mag;
		r = $urandom_range(0, 15);
		if (r < 2) begin
			case ($urandom_range(0, 5))
				0: return 8'h80;
				1: return 8'h81;
				2: return 8'hFF;
				3: return 8'h00;
				4: return 8'h01;
				default: return 8'h7F;
			endcase
		end
		// small speeds of magnitude 0..40
		if (velocity && r < 7) begin
			mag = $urandom_range(0, 40);
			return 8'($urandom_range(0, 1) ? -mag : mag);
		end
		return 8'($urandom());
	endfunction

	task automatic add_row(int cmd, int vel, logic hi, logic lo, bit typed,
			int l_pwm = 0, int s_pwm = 0, bit flag = 1'b0);
		drive_row_t row;
		row.cmd = 8'(cmd);
		row.vel = 8'(vel);
		row.hi = hi;
		row.lo = lo;
		row.typed = typed;
		row.res.large_pwm = 8'(l_pwm);
		row.res.small_pwm = 8'(s_pwm);
		row.res.limited = flag;
		drive_rows.push_back(row);
	endtask

	task automatic offer_request(drive_row_t row, bit gaps);
		s_tvalid <= 1'b1;
		s_tdata <= {row.vel, row.cmd};
		s_tuser <= {row.lo, row.hi};
		do @(posedge clk); while (!s_tready);
		pending_pwm.push_back(row.typed ? row.res : predict_pwm(row.cmd, row.vel, row.hi, row.lo));
		if (gaps && !no_idle && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pwm.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_limits(int large_val, int small_val);
		cfg_we <= 1'b1;
		cfg_index <= becl_pkg::REG_LARGE_LIMIT;
		cfg_data <= 7'(large_val);
		@(posedge clk);
		cfg_index <= becl_pkg::REG_SMALL_LIMIT;
		cfg_data <= 7'(small_val);
		@(posedge clk);
		cfg_we <= 1'b0;
		large_lim = large_val;
		small_lim = small_val;
		@(posedge clk);
	endtask

	// -------- result side --------

	initial begin : result_sink
		int stall_left;
		becl_pkg::result_t got;
		becl_pkg::result_t want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.large_pwm = m_tdata[7:0];
				got.small_pwm = m_tdata[15:8];
				got.limited   = m_tuser[0];
				if (pending_pwm.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: result with nothing pending: %h %h %b", $time,
						got.large_pwm, got.small_pwm, got.limited);
				end else begin
					want = pending_pwm.pop_front();
					if (got.large_pwm !== want.large_pwm) begin
						mismatch_cnt++;
						$display("%0t: large_motor_pwm expected %0d got %0d", $time,
							$signed(want.large_pwm), $signed(got.large_pwm));
					end
					if (got.small_pwm !== want.small_pwm) begin
						mismatch_cnt++;
						$display("%0t: small_motor_pwm expected %0d got %0d", $time,
							$signed(want.small_pwm), $signed(got.small_pwm));
					end
					if (got.limited !== want.limited) begin
						mismatch_cnt++;
						$display("%0t: drive_limited expected %b got %b", $time,
							want.limited, got.limited);
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !no_idle && m_tready && $urandom_range(0, 4) == 0) begin
				stall_left = idle_len();
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// -------- request side --------

	initial begin : stimulus
		int zero_lim_start;
		int lg;
		int sm;
		drive_row_t row;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits of 40
		add_row(0, 0, 0, 0, 1, 0, 0, 0);
		add_row(0, -128, 1, 1, 1, 0, 0, 0);
		add_row(0, 127, 1, 0, 1, 0, 0, 0);
		add_row(127, 0, 0, 0, 1, 40, 40, 1);
		add_row(-128, 0, 0, 0, 1, -40, -40, 1);
		add_row(-127, 0, 0, 0, 1, -40, -40, 1);
		add_row(10, 0, 0, 0, 1, 10, 10, 0);
		add_row(40, 0, 0, 0, 1, 40, 40, 0);
		add_row(41, 0, 0, 0, 1, 40, 40, 1);
		add_row(127, 127, 1, 0, 0);
		add_row(127, -128, 1, 0, 0);
		add_row(-128, -128, 0, 1, 0);
		add_row(-127, 127, 0, 1, 0);
		add_row(127, 127, 1, 1, 0);
		add_row(100, 20, 1, 0, 0);
		add_row(100, 20, 0, 1, 0);
		add_row(100, 20, 0, 0, 0);
		add_row(-1, 1, 1, 0, 0);
		add_row(1, -1, 0, 1, 0);
		add_row(127, 64, 0, 1, 0);
		add_row(-64, -5, 1, 0, 0);
		zero_lim_start = drive_rows.size();
		// zero limits: these non-zero commands end at 0 and are flagged
		add_row(1, 0, 0, 0, 1, 0, 0, 1);
		add_row(-128, 0, 0, 0, 1, 0, 0, 1);
		add_row(0, 90, 0, 1, 1, 0, 0, 0);
		add_row(127, 127, 1, 0, 1, 0, 0, 1);

		foreach (drive_rows[i]) begin
			if (i == zero_lim_start) begin
				settle();
				set_limits(0, 0);
			end
			offer_request(drive_rows[i], 1'b1);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: begin lg = 127; sm = 127; end
				1: begin lg = 0;   sm = 127; end
				2: begin lg = 127; sm = 0;   end
				3: begin lg = 1;   sm = 126; end
				default: begin lg = $urandom_range(0, 127); sm = $urandom_range(0, 127); end
			endcase
			set_limits(lg, sm);
			no_idle = (p == 4);
			// receiver stalls long while requests keep coming back to back
			if (p == 2) hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				row.cmd = pick_byte(1'b0);
				row.vel = pick_byte(1'b1);
				row.hi = $urandom_range(0, 1);
				row.lo = $urandom_range(0, 1);
				row.typed = 1'b0;
				row.res = '0;
				offer_request(row, p != 2);
			end
		end

		settle();
		if (mismatch_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/becl_pkg.sv
design/becl_front.sv
design/becl_div_cell.sv
design/back_emf_current_limiter_unit.sv
sim/tb_back_emf_current_limiter_unit.sv
